@@ hw/rtl/multi_class_bounded_deque_macros.svh @@
// assertion macros used by the mcbd_chk checker
`ifndef MULTI_CLASS_BOUNDED_DEQUE_MACROS_SVH
`define MULTI_CLASS_BOUNDED_DEQUE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MCBD_ASSERT_IMPL(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MCBD_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ hw/rtl/mcbd_pkg.sv @@
package mcbd_pkg;

  localparam int NUM_CLASSES_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int ID_W    = 16;
  localparam int ENTRY_W = ID_W + 1;
  localparam int CLASS_W = 5;
  localparam int OCC_W   = 4;
  localparam int STAT_W  = 2;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_TAKEN = 2'd2,
    ST_EMPTY = 2'd3
  } mcbd_status_t;

  typedef struct packed {
    mcbd_status_t       status;
    logic [OCC_W-1:0]   occupancy;
  } mcbd_res_t;

endpackage

@@ hw/rtl/mcbd_ram.sv @@
module mcbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/mcbd_ctrl.sv @@
module mcbd_ctrl #(
  parameter int NUM_CLASSES = mcbd_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH = mcbd_pkg::QUEUE_DEPTH_DEF,
  localparam int AW = (NUM_CLASSES * QUEUE_DEPTH > 1) ?
                      $clog2(NUM_CLASSES * QUEUE_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic                          action,
  input  logic [mcbd_pkg::CLASS_W-1:0]  class_index,
  input  logic [mcbd_pkg::ID_W-1:0]     entry_id,
  input  logic                          urgent,
  output mcbd_pkg::mcbd_res_t           res,
  output logic                          ram_we,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_addr,
  output logic [mcbd_pkg::ENTRY_W-1:0]  ram_wdata
);

  import mcbd_pkg::*;

  localparam int CW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int EXTW = (CW > CLASS_W) ? CW : CLASS_W;

  logic [HW-1:0]   head_r [NUM_CLASSES];
  logic [CNTW-1:0] cnt_r  [NUM_CLASSES];

  logic [EXTW-1:0] cls_ext;
  logic [CW-1:0]   cls_idx;
  logic            in_range;
  logic [HW-1:0]   head;
  logic [CNTW-1:0] cnt;
  logic [CNTW:0]   tail_sum;
  logic [HW-1:0]   pos;
  logic [HW-1:0]   head_nxt;
  logic [CNTW-1:0] cnt_nxt;
  logic            upd;

  assign cls_ext  = EXTW'(class_index);
  assign cls_idx  = cls_ext[CW-1:0];
  assign in_range = 32'(class_index) < NUM_CLASSES;
  assign head     = head_r[cls_idx];
  assign cnt      = cnt_r[cls_idx];

  always_comb begin
    res.status    = ST_EMPTY;
    res.occupancy = '0;
    head_nxt      = head;
    cnt_nxt       = cnt;
    upd           = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    pos           = head;
    tail_sum      = (CNTW+1)'(head) + (CNTW+1)'(cnt);
    if (tail_sum >= (CNTW+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNTW+1)'(QUEUE_DEPTH);
    end
    if (!in_range) begin
      res.status = (action == ACT_TAKE) ? ST_EMPTY : ST_FULL;
    end else if (action == ACT_ADD) begin
      if (cnt >= CNTW'(QUEUE_DEPTH)) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_ADDED;
        if (urgent) begin
          pos      = (head == '0) ? HW'(QUEUE_DEPTH - 1) : head - HW'(1);
          head_nxt = pos;
        end else begin
          pos = HW'(tail_sum);
        end
        cnt_nxt = cnt + CNTW'(1);
        upd     = go;
        ram_we  = go;
      end
      res.occupancy = OCC_W'(cnt_nxt);
    end else begin
      if (cnt == '0) begin
        res.status = ST_EMPTY;
      end else begin
        res.status = ST_TAKEN;
        head_nxt   = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);
        cnt_nxt    = cnt - CNTW'(1);
        upd        = go;
        ram_re     = go;
      end
      res.occupancy = OCC_W'(cnt_nxt);
    end
  end

  assign ram_addr  = AW'(cls_idx) * AW'(QUEUE_DEPTH) + AW'(pos);
  assign ram_wdata = {urgent, entry_id};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (upd) begin
      head_r[cls_idx] <= head_nxt;
      cnt_r[cls_idx]  <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/multi_class_bounded_deque.sv @@
// Keeps NUM_CLASSES independent bounded deques of up to QUEUE_DEPTH entries each.
// Accepts one word per cycle while the s1 stage can drain, and returns exactly one result
// word per input word, in order. The result word passes through the s1 stage and the
// output register and holds there while the output side stalls. Per-class head and
// count live in flip-flops and are updated in the accept cycle, so back-to-back
// words to the same class see each other; the s1 stage covers the registered read
// port of the entry RAM. Entries need no clearing after reset: only live slots are
// ever read.
module multi_class_bounded_deque #(
  parameter int NUM_CLASSES = mcbd_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH = mcbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [mcbd_pkg::CLASS_W-1:0]  in_class_index,
  input  logic [mcbd_pkg::ID_W-1:0]     in_entry_id,
  input  logic                          in_urgent,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcbd_pkg::STAT_W-1:0]   out_status,
  output logic [mcbd_pkg::ID_W-1:0]     out_taken_id,
  output logic                          out_taken_urgent,
  output logic [mcbd_pkg::OCC_W-1:0]    out_occupancy
);

  import mcbd_pkg::*;

  localparam int RAM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  logic               in_go;
  mcbd_res_t          res;
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  mcbd_res_t          s1_res_r;
  logic               s1_adv;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r;
  logic [ID_W-1:0]    out_taken_id_r;
  logic               out_taken_urgent_r;
  logic [OCC_W-1:0]   out_occupancy_r;
  logic               s1_taken;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_go    = in_valid && in_ready;
  assign s1_taken = s1_res_r.status == ST_TAKEN;

  mcbd_ctrl #(
    .NUM_CLASSES (NUM_CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (in_go),
    .action      (in_action),
    .class_index (in_class_index),
    .entry_id    (in_entry_id),
    .urgent      (in_urgent),
    .res         (res),
    .ram_we      (ram_we),
    .ram_re      (ram_re),
    .ram_addr    (ram_addr),
    .ram_wdata   (ram_wdata)
  );

  mcbd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      s1_valid_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_go) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, ram read data is held until the next read
  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_res_r <= res;
    end
    if (s1_adv) begin
      out_status_r       <= s1_res_r.status;
      out_occupancy_r    <= s1_res_r.occupancy;
      out_taken_id_r     <= s1_taken ? ram_rdata[ID_W-1:0] : '0;
      out_taken_urgent_r <= s1_taken ? ram_rdata[ID_W] : 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_taken_id     = out_taken_id_r;
  assign out_taken_urgent = out_taken_urgent_r;
  assign out_occupancy    = out_occupancy_r;

endmodule

@@ hw/rtl/mcbd_chk.sv @@
`include "multi_class_bounded_deque_macros.svh"

module mcbd_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mcbd_pkg::STAT_W-1:0]   out_status,
  input logic [mcbd_pkg::ID_W-1:0]     out_taken_id,
  input logic                          out_taken_urgent,
  input logic [mcbd_pkg::OCC_W-1:0]    out_occupancy
);

  import mcbd_pkg::*;

  // only a taken word carries entry fields
  `MCBD_ASSERT_IMPL(a_idle_fields, out_valid && (out_status != ST_TAKEN), (out_taken_id == '0) && !out_taken_urgent, "entry fields set on a word that took nothing")

  // an empty queue reports no occupancy
  `MCBD_ASSERT_IMPL(a_empty_occ, out_valid && (out_status == ST_EMPTY), out_occupancy == '0, "empty status with nonzero occupancy")

  // a stalled result holds
  `MCBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_taken_id) && $stable(out_occupancy), "stalled result word changed")

  // an accepted word moves from s1 to the output register when the output drains
  `MCBD_ASSERT_NEXT(a_latency, $past(in_valid && in_ready) && out_ready, out_valid, "result word missing after accept")

endmodule

bind multi_class_bounded_deque mcbd_chk u_mcbd_chk (.*);

@@ sim/mcbd_checker.sv @@
module mcbd_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         in_action,
  input  logic [mcbd_pkg::CLASS_W-1:0] in_class_index,
  input  logic [mcbd_pkg::ID_W-1:0]    in_entry_id,
  input  logic                         in_urgent,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [mcbd_pkg::STAT_W-1:0]  out_status,
  input  logic [mcbd_pkg::ID_W-1:0]    out_taken_id,
  input  logic                         out_taken_urgent,
  input  logic [mcbd_pkg::OCC_W-1:0]   out_occupancy,
  output int                           fail_count,
  output int                           pending_count
);
  import mcbd_pkg::*;

  localparam int NUM_CLASSES = NUM_CLASSES_DEF;
  localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    mcbd_status_t     status;
    logic [ID_W-1:0]  taken_id;
    logic             taken_urgent;
    logic [OCC_W-1:0] occupancy;
  } deque_result_t;

  logic [ENTRY_W-1:0] ring_slots [NUM_CLASSES][QUEUE_DEPTH];
  logic [2:0]         head_ptr [NUM_CLASSES];
  logic [OCC_W-1:0]   fill_level [NUM_CLASSES];
  deque_result_t      expected_results [$];
  int                 errors = 0;

  function automatic deque_result_t deque_step(input logic act,
                                               input logic [CLASS_W-1:0] cls,
                                               input logic [ID_W-1:0] id,
                                               input logic urg);
    deque_result_t res;
    logic [2:0] pos;
    res.status = ST_ADDED;
    res.taken_id = '0;
    res.taken_urgent = 1'b0;
    res.occupancy = '0;
    if (int'(cls) >= NUM_CLASSES) begin
      res.status = (act == ACT_TAKE) ? ST_EMPTY : ST_FULL;
    end else if (act == ACT_ADD) begin
      if (int'(fill_level[cls]) >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        if (urg) begin
          pos = head_ptr[cls] - 3'd1;
          head_ptr[cls] = pos;
        end else begin
          pos = head_ptr[cls] + fill_level[cls][2:0];
        end
        ring_slots[cls][pos] = {urg, id};
        fill_level[cls] = fill_level[cls] + 1'b1;
        res.status = ST_ADDED;
      end
      res.occupancy = fill_level[cls];
    end else begin
      if (fill_level[cls] == '0) begin
        res.status = ST_EMPTY;
      end else begin
        {res.taken_urgent, res.taken_id} = ring_slots[cls][head_ptr[cls]];
        head_ptr[cls] = head_ptr[cls] + 3'd1;
        fill_level[cls] = fill_level[cls] - 1'b1;
        res.status = ST_TAKEN;
      end
      res.occupancy = fill_level[cls];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    deque_result_t exp_res;
    deque_result_t new_res;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_ptr[c] = '0;
        fill_level[c] = '0;
      end
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected: status %0d id %h urgent %0d occ %0d",
                   $time, out_status, out_taken_id, out_taken_urgent, out_occupancy);
          errors++;
        end else begin
          exp_res = expected_results[0];
          expected_results.delete(0);
          if (out_status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_res.status, out_status);
            errors++;
          end
          if (out_taken_id !== exp_res.taken_id) begin
            $display("%0t: taken_id expected %h actual %h", $time, exp_res.taken_id,
                     out_taken_id);
            errors++;
          end
          if (out_taken_urgent !== exp_res.taken_urgent) begin
            $display("%0t: taken_urgent expected %0d actual %0d", $time,
                     exp_res.taken_urgent, out_taken_urgent);
            errors++;
          end
          if (out_occupancy !== exp_res.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, exp_res.occupancy,
                     out_occupancy);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        new_res = deque_step(in_action, in_class_index, in_entry_id, in_urgent);
        expected_results.insert(expected_results.size(), new_res);
      end
    end
    fail_count <= errors;
    pending_count <= expected_results.size();
  end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  import mcbd_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_action = ACT_ADD;
  logic [CLASS_W-1:0] in_class_index = '0;
  logic [ID_W-1:0]    in_entry_id = '0;
  logic               in_urgent = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STAT_W-1:0]  out_status;
  logic [ID_W-1:0]    out_taken_id;
  logic               out_taken_urgent;
  logic [OCC_W-1:0]   out_occupancy;
  int                 fail_count;
  int                 pending_count;
  int                 words_sent = 0;

  multi_class_bounded_deque i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_class_index   (in_class_index),
    .in_entry_id      (in_entry_id),
    .in_urgent        (in_urgent),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_taken_id     (out_taken_id),
    .out_taken_urgent (out_taken_urgent),
    .out_occupancy    (out_occupancy)
  );

  mcbd_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_class_index   (in_class_index),
    .in_entry_id      (in_entry_id),
    .in_urgent        (in_urgent),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_taken_id     (out_taken_id),
    .out_taken_urgent (out_taken_urgent),
    .out_occupancy    (out_occupancy),
    .fail_count       (fail_count),
    .pending_count    (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic act, input logic [CLASS_W-1:0] cls,
                           input logic [ID_W-1:0] id, input logic urg, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_class_index <= cls;
    in_entry_id <= id;
    in_urgent <= urg;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // output side: random stalls plus one long hold-off to back up the pipe
  initial begin
    int r;
    int len;
    bit held_once;
    held_once = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!held_once && words_sent >= 400) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        len = 300;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 60) begin
          out_ready <= 1'b1;
          len = $urandom_range(50, 120);
        end else if (r < 92) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          len = $urandom_range(10, 40);
        end
      end
      repeat (len) @(negedge clk);
    end
  end

  initial begin
    int r;
    int phase_left;
    bit fill_phase;
    logic act;
    logic urg;
    logic [CLASS_W-1:0] cls;
    logic [CLASS_W-1:0] hot_a;
    logic [CLASS_W-1:0] hot_b;
    phase_left = 0;
    fill_phase = 1'b0;
    hot_a = '0;
    hot_b = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // empty take, urgent ordering, extreme ids
    send_word(ACT_TAKE, 5'd0, 16'h1234, 1'b1, 0);
    send_word(ACT_ADD, 5'd0, 16'h0000, 1'b0, 0);
    send_word(ACT_ADD, 5'd0, 16'hFFFF, 1'b1, 0);
    send_word(ACT_TAKE, 5'd0, 16'h0000, 1'b0, 0);
    send_word(ACT_TAKE, 5'd0, 16'hFFFF, 1'b0, 1);
    send_word(ACT_TAKE, 5'd0, 16'h0000, 1'b0, 0);
    // fill the top class, then overflow with regular and urgent adds
    for (int k = 0; k < 8; k++) begin
      send_word(ACT_ADD, 5'd31, (k % 2) ? 16'hAAAA : 16'h5555, k[0] ^ k[1], 0);
    end
    send_word(ACT_ADD, 5'd31, 16'hFFFF, 1'b0, 0);
    send_word(ACT_ADD, 5'd31, 16'hFFFF, 1'b1, 2);
    for (int k = 0; k < 3; k++) begin
      send_word(ACT_TAKE, 5'd31, 16'hFFFF, 1'b1, 0);
    end

    for (int n = 0; n < 1250; n++) begin
      if (phase_left == 0) begin
        fill_phase = !fill_phase;
        phase_left = $urandom_range(20, 80);
        hot_a = CLASS_W'($urandom_range(0, 31));
        hot_b = CLASS_W'($urandom_range(0, 31));
      end
      phase_left--;
      r = $urandom_range(0, 99);
      act = fill_phase ? ((r < 30) ? ACT_TAKE : ACT_ADD) : ((r < 70) ? ACT_TAKE : ACT_ADD);
      r = $urandom_range(0, 99);
      cls = (r < 45) ? hot_a : (r < 80) ? hot_b : CLASS_W'($urandom_range(0, 31));
      urg = $urandom_range(0, 1);
      send_word(act, cls, ID_W'($urandom), urg, ((n / 150) % 3 == 0) ? 0 : idle_gap());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/mcbd_pkg.sv
hw/rtl/mcbd_ram.sv
hw/rtl/mcbd_ctrl.sv
hw/rtl/multi_class_bounded_deque.sv
hw/rtl/mcbd_chk.sv
sim/mcbd_checker.sv
sim/tb_top.sv
